// ----- hw/rtl/rsp_pkg.sv -----
`default_nettype none
package rsp_pkg;

  localparam int unsigned MaxWidthDef  = 64;
  localparam int unsigned MaxHeightDef = 64;
  localparam int unsigned RowW         = 64;
  localparam int unsigned DimW         = 7;
  localparam int unsigned IdxW         = 6;

  typedef enum logic [1:0] {
    OP_SQUARE   = 2'd0,
    OP_TRIANGLE = 2'd1,
    OP_LINE     = 2'd2,
    OP_CLEAR    = 2'd3
  } op_e;

  typedef enum logic [0:0] {
    CFG_WIDTH  = 1'b0,
    CFG_HEIGHT = 1'b1
  } cfg_idx_e;

  typedef struct packed {
    logic [1:0]        op;
    logic signed [7:0] start_x;
    logic signed [7:0] start_y;
    logic signed [7:0] end_x;
    logic signed [7:0] end_y;
    logic [6:0]        size;
    logic              go_left;
    logic              go_up;
  } cmd_t;

  typedef struct packed {
    logic            status;
    logic [5:0]      row_index;
    logic [RowW-1:0] row_bits;
    logic            last;
  } res_t;

  // Request from the sequencer to the canvas memory.
  typedef struct packed {
    logic            rd;
    logic            wr;
    logic [IdxW-1:0] addr;
    logic [RowW-1:0] wdata;
  } mem_req_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CHECK,
    ST_CLEAR,
    ST_SQ_RD,
    ST_SQ_WR,
    ST_LN_RD,
    ST_LN_WR,
    ST_OUT_RD,
    ST_OUT_WAIT,
    ST_OUT_SEND,
    ST_ERR
  } state_e;

endpackage
`default_nettype wire

// ----- hw/rtl/rsp_canvas_mem.sv -----
`default_nettype none
module rsp_canvas_mem
  import rsp_pkg::*;
#(
  parameter int unsigned MaxHeight = MaxHeightDef
) (
  input  wire logic            clk_i,
  input  mem_req_t             req_i,
  output logic [RowW-1:0]      rdata_o
);

  logic [RowW-1:0] mem_q [MaxHeight];

  always_ff @(posedge clk_i) begin
    if (req_i.wr) begin
      mem_q[req_i.addr[$clog2(MaxHeight)-1:0]] <= req_i.wdata;
    end
    if (req_i.rd) begin
      rdata_o <= mem_q[req_i.addr[$clog2(MaxHeight)-1:0]];
    end
  end

endmodule
`default_nettype wire

// ----- hw/rtl/rsp_seq.sv -----
`default_nettype none
module rsp_seq
  import rsp_pkg::*;
#(
  parameter int unsigned MaxWidth  = MaxWidthDef,
  parameter int unsigned MaxHeight = MaxHeightDef
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            in_valid_i,
  output logic                 in_ready_o,
  input  cmd_t                 in_data_i,
  output logic                 out_valid_o,
  input  wire logic            out_ready_i,
  output res_t                 out_data_o,
  input  wire logic [DimW-1:0] width_i,
  input  wire logic [DimW-1:0] height_i,
  output mem_req_t             mem_req_o,
  input  wire logic [RowW-1:0] mem_rdata_i,
  output logic                 busy_o
);

  state_e state_q, state_d;
  cmd_t   cmd_q;
  logic signed [9:0] w_s, h_s;
  logic signed [9:0] sx, sy, ex, ey, sz;
  logic signed [9:0] x_q, x_d, y_q, y_d, bx_q, bx_d, by_q, by_d;
  logic [1:0]  seg_q, seg_d;
  logic        endm_q, endm_d;
  logic [IdxW:0] row_q, row_d;
  logic [IdxW:0] h_eff;
  logic [6:0]  w_eff;
  logic        ok;
  logic signed [9:0] lx, uy;
  logic [RowW-1:0] sq_mask, colmask, bitm;
  logic signed [9:0] mx, my;
  logic        at_end, mark_ok;
  res_t        res_q, res_d;
  logic        ov_q, ov_d;

  assign w_eff = (width_i == '0) ? 7'd1 :
                 (width_i > 7'(MaxWidth)) ? 7'(MaxWidth) : width_i;
  assign h_eff = (height_i == '0) ? 7'd1 :
                 (height_i > 7'(MaxHeight)) ? 7'(MaxHeight) : height_i;
  assign w_s = 10'(signed'({3'b0, w_eff}));
  assign h_s = 10'(signed'({3'b0, h_eff}));
  assign sx = 10'(cmd_q.start_x);
  assign sy = 10'(cmd_q.start_y);
  assign ex = 10'(cmd_q.end_x);
  assign ey = 10'(cmd_q.end_y);
  assign sz = 10'(signed'({3'b0, cmd_q.size}));
  assign lx = cmd_q.go_left ? sx - sz + 10'sd1 : sx + sz - 10'sd1;
  assign uy = cmd_q.go_up ? sy - sz + 10'sd1 : sy + sz - 10'sd1;

  always_comb begin
    ok = 1'b1;
    case (op_e'(cmd_q.op))
      OP_SQUARE: ok = !(sx < 0 || sy < 0 || sx + sz > w_s || sy + sz > h_s);
      OP_TRIANGLE: begin
        ok = sx >= 0 && sx < w_s && sy >= 0 && sy < h_s && sz >= 10'sd1;
        if (cmd_q.go_left ? lx < 0 : sx + sz > w_s) ok = 1'b0;
        if (cmd_q.go_up ? uy < 0 : sy + sz > h_s) ok = 1'b0;
      end
      OP_LINE: ok = sx >= 0 && sx < w_s && sy >= 0 && sy < h_s &&
                    ex >= 0 && ex < w_s && ey >= 0 && ey < h_s;
      default: ok = 1'b1;
    endcase
  end

  assign sq_mask = ((cmd_q.size >= 7'd64) ? {RowW{1'b1}} :
                    ((RowW'(1) << cmd_q.size[5:0]) - RowW'(1))) << sx[5:0];
  assign colmask = (w_eff >= 7'd64) ? {RowW{1'b1}} :
                   ((RowW'(1) << w_eff[5:0]) - RowW'(1));
  assign at_end = (x_q == bx_q) && (y_q == by_q);
  assign mx = endm_q ? bx_q : x_q;
  assign my = endm_q ? by_q : y_q;
  assign mark_ok = mx >= 0 && mx < 10'sd64 && my >= 0 && my < 10'(MaxHeight);
  assign bitm = RowW'(1) << mx[5:0];

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: if (in_valid_i) state_d = ST_CHECK;
      ST_CHECK: begin
        if (op_e'(cmd_q.op) == OP_CLEAR) state_d = ST_CLEAR;
        else if (!ok) state_d = ST_ERR;
        else if (op_e'(cmd_q.op) == OP_SQUARE)
          state_d = (cmd_q.size == '0) ? ST_OUT_RD : ST_SQ_RD;
        else state_d = ST_LN_RD;
      end
      ST_CLEAR: if (row_q == 7'(MaxHeight - 1)) state_d = ST_IDLE;
      ST_SQ_RD: state_d = ST_SQ_WR;
      ST_SQ_WR: state_d = (row_q + 7'd1 == 7'(sz)) ? ST_OUT_RD : ST_SQ_RD;
      ST_LN_RD: begin
        if (!endm_q && at_end)
          state_d = (seg_q == 2'd2 || op_e'(cmd_q.op) == OP_LINE) ?
                    ST_OUT_RD : ST_LN_RD;
        else if (mark_ok) state_d = ST_LN_WR;
      end
      ST_LN_WR: state_d = ST_LN_RD;
      ST_OUT_RD: state_d = ST_OUT_WAIT;
      ST_OUT_WAIT: state_d = ST_OUT_SEND;
      ST_OUT_SEND: if (!ov_q || out_ready_i)
        state_d = (row_q + 7'd1 == h_eff) ? ST_IDLE : ST_OUT_RD;
      ST_ERR: if (!ov_q || out_ready_i) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready_o = (state_q == ST_IDLE);
    mem_req_o  = '0;
    row_d = row_q; x_d = x_q; y_d = y_q; bx_d = bx_q; by_d = by_q;
    seg_d = seg_q; endm_d = endm_q;
    res_d = res_q;
    ov_d  = ov_q && !out_ready_i;
    case (state_q)
      ST_CHECK: begin
        row_d = '0; seg_d = '0; endm_d = 1'b1;
        x_d = sx; y_d = sy;
        if (op_e'(cmd_q.op) == OP_LINE) begin
          bx_d = ex; by_d = ey;
        end else begin
          bx_d = lx; by_d = sy;
        end
      end
      ST_CLEAR: begin
        mem_req_o.wr = 1'b1;
        mem_req_o.addr = row_q[IdxW-1:0];
        row_d = row_q + 7'd1;
      end
      ST_SQ_RD: begin
        mem_req_o.rd = 1'b1;
        mem_req_o.addr = 6'(sy + 10'(row_q));
      end
      ST_SQ_WR: begin
        mem_req_o.wr = 1'b1;
        mem_req_o.addr = 6'(sy + 10'(row_q));
        mem_req_o.wdata = mem_rdata_i | sq_mask;
        row_d = (row_q + 7'd1 == 7'(sz)) ? '0 : row_q + 7'd1;
      end
      ST_LN_RD: begin
        if (!endm_q && at_end) begin
          seg_d = seg_q + 2'd1; endm_d = 1'b1; row_d = '0;
          case (seg_q)
            2'd0: begin x_d = sx; y_d = sy; bx_d = sx; by_d = uy; end
            default: begin x_d = lx; y_d = sy; bx_d = sx; by_d = uy; end
          endcase
        end else if (mark_ok) begin
          mem_req_o.rd = 1'b1;
          mem_req_o.addr = my[IdxW-1:0];
        end else if (!endm_q) begin
          x_d = x_q + ((x_q < bx_q) ? 10'sd1 : (x_q == bx_q) ? 10'sd0 : -10'sd1);
          y_d = y_q + ((y_q < by_q) ? 10'sd1 : (y_q == by_q) ? 10'sd0 : -10'sd1);
        end else endm_d = 1'b0;
      end
      ST_LN_WR: begin
        mem_req_o.wr = 1'b1;
        mem_req_o.addr = my[IdxW-1:0];
        mem_req_o.wdata = mem_rdata_i | bitm;
        if (endm_q) endm_d = 1'b0;
        else begin
          x_d = x_q + ((x_q < bx_q) ? 10'sd1 : (x_q == bx_q) ? 10'sd0 : -10'sd1);
          y_d = y_q + ((y_q < by_q) ? 10'sd1 : (y_q == by_q) ? 10'sd0 : -10'sd1);
        end
      end
      ST_OUT_RD: begin
        mem_req_o.rd = 1'b1;
        mem_req_o.addr = row_q[IdxW-1:0];
      end
      ST_OUT_SEND: if (!ov_q || out_ready_i) begin
        ov_d = 1'b1;
        res_d.status = 1'b0;
        res_d.row_index = row_q[IdxW-1:0];
        res_d.row_bits = mem_rdata_i & colmask;
        res_d.last = (row_q + 7'd1 == h_eff);
        row_d = row_q + 7'd1;
      end
      ST_ERR: if (!ov_q || out_ready_i) begin
        ov_d = 1'b1;
        res_d = '0;
        res_d.status = 1'b1;
        res_d.last = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
      row_q <= '0;
      ov_q <= 1'b0;
      seg_q <= '0;
      endm_q <= 1'b0;
    end else begin
      state_q <= state_d;
      row_q <= row_d;
      ov_q <= ov_d;
      seg_q <= seg_d;
      endm_q <= endm_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) cmd_q <= in_data_i;
    x_q <= x_d; y_q <= y_d; bx_q <= bx_d; by_q <= by_d;
    res_q <= res_d;
  end

  assign out_valid_o = ov_q;
  assign out_data_o  = res_q;
  assign busy_o      = (state_q != ST_IDLE);

endmodule
`default_nettype wire

// ----- hw/rtl/raster_shape_plotter.sv -----
// Channel | Direction | Handshake                  | Payload
// in      | input     | in_valid_i / in_ready_o    | in_data_i (cmd_t)
// out     | output    | out_valid_o / out_ready_i  | out_data_o (res_t)
// cfg     | input     | cfg_valid_i / cfg_ready_o  | cfg_index_i, cfg_data_i
// A command takes a check step, then a canvas read and a write per square row or per
// line point, then a read, a wait and a send step per streamed row.
// The single-port canvas memory sets this order of steps.
// After reset a clearing pass over all MaxHeight rows runs before the first item is taken.
// A clear command clears all MaxHeight rows and gives no result.
// A stalled output holds the sequencer; nothing is lost.
`default_nettype none
module raster_shape_plotter
  import rsp_pkg::*;
#(
  parameter int unsigned MaxWidth  = MaxWidthDef,
  parameter int unsigned MaxHeight = MaxHeightDef
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            in_valid_i,
  output logic                 in_ready_o,
  input  cmd_t                 in_data_i,
  output logic                 out_valid_o,
  input  wire logic            out_ready_i,
  output res_t                 out_data_o,
  input  wire logic            cfg_valid_i,
  output logic                 cfg_ready_o,
  input  wire logic            cfg_index_i,
  input  wire logic [DimW-1:0] cfg_data_i
);

  logic [DimW-1:0] width_q, height_q;
  mem_req_t        req;
  logic [RowW-1:0] rdata;
  logic            busy;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= 7'd64;
      height_q <= 7'd64;
    end else if (cfg_valid_i) begin
      if (cfg_idx_e'(cfg_index_i) == CFG_WIDTH) width_q <= cfg_data_i;
      else height_q <= cfg_data_i;
    end
  end

  rsp_seq #(.MaxWidth(MaxWidth), .MaxHeight(MaxHeight)) u_seq (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .in_data_i,
    .out_valid_o, .out_ready_i, .out_data_o,
    .width_i(width_q), .height_i(height_q),
    .mem_req_o(req), .mem_rdata_i(rdata), .busy_o(busy)
  );

  rsp_canvas_mem #(.MaxHeight(MaxHeight)) u_mem (
    .clk_i, .req_i(req), .rdata_o(rdata)
  );

  a_ready_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o |-> !busy) else $error("ready while busy");
  a_no_rdwr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(req.rd && req.wr)) else $error("read and write together");
  a_err_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.status) |-> out_data_o.last) else $error("error not last");

endmodule
`default_nettype wire

// ----- verif/tb_top.sv -----
`timescale 1ns / 1ps
module tb_top;
  import rsp_pkg::*;

  typedef struct {
    cmd_t cmd;
    bit   is_err;
  } plot_row_t;

  logic     clk;
  logic     rst_n;
  logic     in_valid;
  logic     in_ready;
  cmd_t     in_data;
  logic     out_valid;
  logic     out_ready;
  res_t     out_data;
  logic     cfg_valid;
  logic     cfg_ready;
  cfg_idx_e cfg_index;
  logic [DimW-1:0] cfg_data;

  logic [RowW-1:0] canvas [MaxHeightDef];
  logic [DimW-1:0] width_reg;
  logic [DimW-1:0] height_reg;
  res_t            rows_due [$];
  int              fail_count;
  int              idle_cycles;
  int              send_gap;
  bit              hold_req;

  raster_shape_plotter i_dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  function automatic int eff_dim(logic [DimW-1:0] r);
    if (r < 1) return 1;
    if (r > 64) return 64;
    return int'(r);
  endfunction

  function automatic void mark_cell(int x, int y);
    if (x >= 0 && x < 64 && y >= 0 && y < 64) canvas[y][x] = 1'b1;
  endfunction

  function automatic int step_dir(int v, int t);
    return v < t ? 1 : (v == t ? 0 : -1);
  endfunction

  function automatic void plot_segment(int ax, int ay, int bx, int by);
    int x;
    int y;
    int guard;
    x = ax;
    y = ay;
    guard = 0;
    mark_cell(bx, by);
    while ((x != bx || y != by) && guard < 256) begin
      mark_cell(x, y);
      x += step_dir(x, bx);
      y += step_dir(y, by);
      guard++;
    end
  endfunction

  function automatic void predict_rows(cmd_t c);
    int sx;
    int sy;
    int ex;
    int ey;
    int sz;
    int w;
    int h;
    int lx;
    int uy;
    bit ok;
    logic [RowW-1:0] mask;
    res_t r;
    sx = $signed(c.start_x);
    sy = $signed(c.start_y);
    ex = $signed(c.end_x);
    ey = $signed(c.end_y);
    sz = int'(c.size);
    w = eff_dim(width_reg);
    h = eff_dim(height_reg);
    ok = 1'b1;
    case (op_e'(c.op))
      OP_CLEAR: begin
        foreach (canvas[i]) canvas[i] = '0;
        return;
      end
      OP_SQUARE: begin
        if (sx < 0 || sy < 0 || sx + sz > w || sy + sz > h) ok = 1'b0;
        else
          for (int i = 0; i < sz; i++)
            for (int j = 0; j < sz; j++) mark_cell(sx + j, sy + i);
      end
      OP_TRIANGLE: begin
        if (!(sx >= 0 && sx < w && sy >= 0 && sy < h) || sz < 1) ok = 1'b0;
        else begin
          if (c.go_left) begin
            lx = sx - sz + 1;
            if (lx < 0) ok = 1'b0;
          end else begin
            lx = sx + sz - 1;
            if (sx + sz > w) ok = 1'b0;
          end
          if (c.go_up) begin
            uy = sy - sz + 1;
            if (uy < 0) ok = 1'b0;
          end else begin
            uy = sy + sz - 1;
            if (sy + sz > h) ok = 1'b0;
          end
          if (ok) begin
            plot_segment(sx, sy, lx, sy);
            plot_segment(sx, sy, sx, uy);
            plot_segment(lx, sy, sx, uy);
          end
        end
      end
      default: begin
        if (!(sx >= 0 && sx < w && sy >= 0 && sy < h) ||
            !(ex >= 0 && ex < w && ey >= 0 && ey < h)) ok = 1'b0;
        else plot_segment(sx, sy, ex, ey);
      end
    endcase
    if (!ok) begin
      r = '{status: 1'b1, row_index: '0, row_bits: '0, last: 1'b1};
      rows_due.push_back(r);
      return;
    end
    mask = (w >= 64) ? '1 : ((64'd1 << w) - 64'd1);
    for (int i = 0; i < h; i++) begin
      r = '{status: 1'b0, row_index: i[5:0], row_bits: canvas[i] & mask,
            last: (i == h - 1)};
      rows_due.push_back(r);
    end
  endfunction

  function automatic cmd_t mk(op_e op, int sx, int sy, int ex, int ey, int sz,
                              bit lf, bit up);
    cmd_t c;
    c.op = op;
    c.start_x = sx[7:0];
    c.start_y = sy[7:0];
    c.end_x = ex[7:0];
    c.end_y = ey[7:0];
    c.size = sz[6:0];
    c.go_left = lf;
    c.go_up = up;
    return c;
  endfunction

  task automatic send_cmd(cmd_t c, bit is_err);
    if (send_gap != 0) repeat (send_gap) @(posedge clk);
    in_valid <= 1'b1;
    in_data <= c;
    do @(posedge clk); while (!in_ready);
    if (is_err) rows_due.push_back('{status: 1'b1, row_index: '0, row_bits: '0, last: 1'b1});
    else predict_rows(c);
    send_gap = $urandom_range(0, 10);
    if (send_gap != 0) in_valid <= 1'b0;
  endtask

  task automatic drain_wait();
    if (send_gap == 0) in_valid <= 1'b0;
    send_gap = 1;
    while (rows_due.size() != 0) @(posedge clk);
    repeat (700) @(posedge clk);
  endtask

  task automatic write_reg(cfg_idx_e idx, logic [DimW-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    if (idx == CFG_WIDTH) width_reg = val;
    else height_reg = val;
  endtask

  function automatic int pick_coord(int lim);
    if ($urandom_range(0, 9) < 8) return $urandom_range(0, lim - 1);
    return $urandom_range(0, 255);
  endfunction

  function automatic cmd_t random_cmd();
    int w;
    int h;
    int sel;
    int sz;
    op_e op;
    w = eff_dim(width_reg);
    h = eff_dim(height_reg);
    sel = $urandom_range(0, 15);
    op = sel < 5 ? OP_SQUARE : (sel < 10 ? OP_TRIANGLE : (sel < 15 ? OP_LINE : OP_CLEAR));
    sz = ($urandom_range(0, 9) < 8) ? $urandom_range(0, 8) : $urandom_range(0, 127);
    return mk(op, pick_coord(w), pick_coord(h), pick_coord(w), pick_coord(h), sz,
              $urandom_range(0, 1), $urandom_range(0, 1));
  endfunction

  always begin
    int n;
    n = $urandom_range(0, 10);
    if (hold_req) begin
      n = 1500;
      hold_req = 1'b0;
    end
    if (n != 0) begin
      out_ready <= 1'b0;
      repeat (n) @(posedge clk);
    end
    out_ready <= 1'b1;
    do @(posedge clk); while (!(out_valid && out_ready && rst_n));
  end

  always @(posedge clk) begin
    res_t e;
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
        idle_cycles <= 0;
      else
        idle_cycles <= idle_cycles + 1;
      if (idle_cycles > 20000) begin
        $display("tb: failure");
        $finish;
      end
      if (out_valid && out_ready) begin
        if (rows_due.size() == 0) begin
          $error("unexpected item: %p", out_data);
          fail_count++;
        end else begin
          e = rows_due.pop_front();
          if (out_data.status !== e.status) begin
            $error("status: expected %0d, got %0d", e.status, out_data.status);
            fail_count++;
          end
          if (out_data.row_index !== e.row_index) begin
            $error("row_index: expected %0d, got %0d", e.row_index, out_data.row_index);
            fail_count++;
          end
          if (out_data.row_bits !== e.row_bits) begin
            $error("row_bits: expected %h, got %h", e.row_bits, out_data.row_bits);
            fail_count++;
          end
          if (out_data.last !== e.last) begin
            $error("last: expected %0d, got %0d", e.last, out_data.last);
            fail_count++;
          end
        end
      end
    end
  end

  initial begin
    plot_row_t plan [$];
    logic [DimW-1:0] widths [5];
    logic [DimW-1:0] heights [5];
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    out_ready = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = CFG_WIDTH;
    cfg_data = '0;
    fail_count = 0;
    idle_cycles = 0;
    send_gap = 0;
    hold_req = 1'b0;
    width_reg = 7'd64;
    height_reg = 7'd64;
    foreach (canvas[i]) canvas[i] = '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    plan.push_back('{mk(OP_LINE, 0, 0, 63, 63, 0, 0, 0), 0});
    plan.push_back('{mk(OP_SQUARE, 0, 0, 0, 0, 64, 0, 0), 0});
    plan.push_back('{mk(OP_CLEAR, 0, 0, 0, 0, 0, 0, 0), 0});
    plan.push_back('{mk(OP_SQUARE, 0, 0, 0, 0, 0, 0, 0), 0});
    plan.push_back('{mk(OP_SQUARE, -1, 0, 0, 0, 1, 0, 0), 1});
    plan.push_back('{mk(OP_SQUARE, 1, 0, 0, 0, 64, 0, 0), 1});
    plan.push_back('{mk(OP_SQUARE, 127, -128, 0, 0, 127, 1, 1), 1});
    plan.push_back('{mk(OP_TRIANGLE, 10, 10, 0, 0, 0, 0, 0), 1});
    plan.push_back('{mk(OP_TRIANGLE, -128, 10, 0, 0, 3, 0, 0), 1});
    plan.push_back('{mk(OP_TRIANGLE, 10, 10, 0, 0, 5, 1, 1), 0});
    plan.push_back('{mk(OP_TRIANGLE, 20, 20, 0, 0, 5, 0, 0), 0});
    plan.push_back('{mk(OP_TRIANGLE, 30, 10, 0, 0, 6, 1, 0), 0});
    plan.push_back('{mk(OP_TRIANGLE, 40, 50, 0, 0, 7, 0, 1), 0});
    plan.push_back('{mk(OP_TRIANGLE, 63, 63, 0, 0, 1, 0, 0), 0});
    plan.push_back('{mk(OP_TRIANGLE, 2, 2, 0, 0, 4, 1, 0), 1});
    plan.push_back('{mk(OP_TRIANGLE, 62, 62, 0, 0, 64, 0, 1), 1});
    plan.push_back('{mk(OP_LINE, 5, 20, 40, 3, 0, 0, 0), 0});
    plan.push_back('{mk(OP_LINE, 127, -128, 0, 0, 0, 0, 0), 1});
    plan.push_back('{mk(OP_LINE, 0, 0, -1, 64, 0, 0, 0), 1});
    plan.push_back('{mk(OP_LINE, 63, 0, 0, 63, 0, 0, 0), 0});
    plan.push_back('{mk(OP_CLEAR, -1, -1, -1, -1, 127, 1, 1), 0});
    plan.push_back('{mk(OP_SQUARE, 62, 62, 0, 0, 2, 0, 0), 0});
    foreach (plan[i]) send_cmd(plan[i].cmd, plan[i].is_err);
    drain_wait();

    widths = '{7'd1, 7'd64, 7'd0, 7'd127, 7'd0};
    heights = '{7'd64, 7'd1, 7'd127, 7'd0, 7'd0};
    widths[4] = $urandom_range(2, 63);
    heights[4] = $urandom_range(2, 63);
    for (int ph = 0; ph < 6; ph++) begin
      if (ph > 0) begin
        write_reg(CFG_WIDTH, widths[ph - 1]);
        write_reg(CFG_HEIGHT, heights[ph - 1]);
        cfg_valid <= 1'b0;
      end
      for (int k = 0; k < 50; k++) begin
        if (ph == 1 && k == 10) hold_req = 1'b1;
        send_cmd(random_cmd(), 1'b0);
      end
      drain_wait();
    end

    if (rows_due.size() != 0) begin
      $error("%0d items never arrived", rows_due.size());
      fail_count++;
    end
    if (fail_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
hw/rtl/rsp_pkg.sv
hw/rtl/rsp_canvas_mem.sv
hw/rtl/rsp_seq.sv
hw/rtl/raster_shape_plotter.sv
verif/tb_top.sv
